[sv/tpmsfb_pkg.sv]
// ----------------------------------------------------------------------------
// tpmsfb_pkg
// Shared constants and types for the tire-sensor frame builder: frame
// geometry, preamble pattern, register indexes and CRC unit control.
// ----------------------------------------------------------------------------
`default_nettype none

package tpmsfb_pkg;

	// Frame geometry
	localparam int unsigned FRAME_NIBBLES   = 45;
	localparam int unsigned PREAMBLE_NIBS   = 8;
	localparam int unsigned CODED_NIBS      = 36;
	localparam int unsigned PAYLOAD_BYTES   = 8;
	localparam int unsigned NIB_IDX_W       = 6;
	localparam int unsigned CRC_IDX_W       = 4;

	localparam logic [31:0] PREAMBLE        = 32'h5555_5556;
	localparam logic [NIB_IDX_W-1:0] LAST_NIB_IDX = NIB_IDX_W'(FRAME_NIBBLES - 1);
	localparam logic [NIB_IDX_W-1:0] CODED_END_IDX =
		NIB_IDX_W'(PREAMBLE_NIBS + CODED_NIBS);

	// Configuration registers
	localparam logic [15:0] FILLER_RESET    = 16'hFFFF;
	localparam logic [7:0]  CRC_INIT        = 8'h00;

	typedef enum logic {
		CFG_POLARITY = 1'b0,
		CFG_FILLER   = 1'b1
	} cfg_idx_t;

	// Control from the sequencer to the CRC unit
	typedef struct packed {
		logic clear;
		logic step;
	} crc_ctrl_t;

endpackage

`default_nettype wire

[sv/tpmsfb_crc.sv]
// ----------------------------------------------------------------------------
// tpmsfb_crc
// CRC-8 accumulator (poly 0x07, MSB first); folds in one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmsfb_crc
	import tpmsfb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire crc_ctrl_t ctrl,
	input  wire logic [7:0] data,
	output logic [7:0]     crc
);

	localparam logic [7:0] POLY = 8'h07;

	logic [7:0] crc_q;
	logic [7:0] next_w;

	// One byte through the polynomial divider, eight bit steps
	always_comb begin
		next_w = crc_q ^ data;
		for (int k = 0; k < 8; k++) begin
			if (next_w[7]) begin
				next_w = {next_w[6:0], 1'b0} ^ POLY;
			end else begin
				next_w = {next_w[6:0], 1'b0};
			end
		end
	end

	// Hold, clear or advance the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.clear) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.step) begin
			crc_q <= next_w;
		end
	end

	assign crc = crc_q;

endmodule

`default_nettype wire

[sv/tpmsfb_coder.sv]
// ----------------------------------------------------------------------------
// tpmsfb_coder
// Forms the line nibble for a frame position: preamble, Manchester-coded
// payload and checksum, or the trailing zero nibble.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmsfb_coder
	import tpmsfb_pkg::*;
(
	input  wire logic [NIB_IDX_W-1:0] nib_idx,
	input  wire logic [63:0]          payload,
	input  wire logic [7:0]           crc,
	input  wire logic                 polarity,
	output logic [3:0]                nibble
);

	logic [7:0]           bytes_w [PAYLOAD_BYTES+1];
	logic [NIB_IDX_W-1:0] coded_idx;
	logic [3:0]           byte_sel;
	logic [7:0]           sel_byte;
	logic [1:0]           pairs_w [4];
	logic [1:0]           pair;
	logic                 b_hi;
	logic                 b_lo;
	logic [31:0]          pre_shift;

	// Split the payload word into bytes, checksum last
	always_comb begin
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			bytes_w[i] = payload[63 - 8*i -: 8];
		end
		bytes_w[PAYLOAD_BYTES] = crc;
	end

	// Two data bits per coded nibble
	assign coded_idx = nib_idx - NIB_IDX_W'(PREAMBLE_NIBS);
	assign byte_sel  = coded_idx[5:2];
	assign sel_byte  = bytes_w[byte_sel];
	assign pairs_w[0] = sel_byte[7:6];
	assign pairs_w[1] = sel_byte[5:4];
	assign pairs_w[2] = sel_byte[3:2];
	assign pairs_w[3] = sel_byte[1:0];
	assign pair = pairs_w[coded_idx[1:0]];
	assign b_hi = pair[1] ^ polarity;
	assign b_lo = pair[0] ^ polarity;

	assign pre_shift = PREAMBLE << {nib_idx[2:0], 2'b00};

	// Select the frame section
	always_comb begin
		priority if (nib_idx < NIB_IDX_W'(PREAMBLE_NIBS)) begin
			nibble = pre_shift[31:28];
		end else if (nib_idx < CODED_END_IDX) begin
			nibble = {b_hi, ~b_hi, b_lo, ~b_lo};
		end else begin
			nibble = 4'b0000;
		end
	end

endmodule

`default_nettype wire

[sv/tpms_frame_builder_unit.sv]
// After a reading transfer the sequencer enters run, then loads the first nibble into the output register.
// Throughput: one nibble per cycle while the output does not stall;
// the next reading is taken once the last nibble sits in the output register.
// The CRC unit folds one byte per cycle, eight bytes in all, alongside the preamble output.
// Reset: sequencer idle, no output valid, polarity 0, filler word 0xFFFF, CRC 0.
// ----------------------------------------------------------------------------
// tpms_frame_builder_unit
// Builds a 180-bit tire-sensor transmit frame from one reading and sends
// it out as 45 nibbles, first-sent bit in the MSB, with a last mark.
// ----------------------------------------------------------------------------
`default_nettype none

module tpms_frame_builder_unit
	import tpmsfb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	// Reading channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [23:0] sensor_id,
	input  wire logic [9:0]  pressure_code,
	input  wire logic [7:0]  temperature_code,
	input  wire logic [5:0]  flag_bits,
	// Nibble channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       symbol_nibble,
	output logic             last_nibble
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t               state_q;
	logic                 polarity_q;
	logic [15:0]          filler_q;
	logic [63:0]          payload_q;
	logic [NIB_IDX_W-1:0] nib_q;
	logic [CRC_IDX_W-1:0] crc_idx_q;
	logic                 out_valid_q;
	logic [3:0]           symbol_q;
	logic                 last_q;

	logic       in_xfer;
	logic       load;
	crc_ctrl_t  crc_ctrl;
	logic [7:0] crc_w;
	logic [7:0] crc_byte_w;
	logic [3:0] nibble_w;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q <= 1'b0;
			filler_q   <= FILLER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_POLARITY: polarity_q <= cfg_data[0];
				CFG_FILLER:   filler_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign load     = (state_q == ST_RUN) && (!out_valid_q || !out_stall);

	// Capture the payload word, id bytes reversed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			payload_q <= {flag_bits, pressure_code, temperature_code,
				sensor_id[7:0], sensor_id[15:8], sensor_id[23:16], filler_q};
		end
	end

	// CRC runs over the eight payload bytes while the preamble goes out
	assign crc_ctrl.clear = in_xfer;
	assign crc_ctrl.step  = (state_q == ST_RUN) && !crc_idx_q[CRC_IDX_W-1];
	assign crc_byte_w     = payload_q[63 - 8*crc_idx_q[2:0] -: 8];

	tpmsfb_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (crc_byte_w),
		.crc    (crc_w)
	);

	tpmsfb_coder u_coder (
		.nib_idx  (nib_q),
		.payload  (payload_q),
		.crc      (crc_w),
		.polarity (polarity_q),
		.nibble   (nibble_w)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nib_q       <= '0;
			crc_idx_q   <= '0;
			out_valid_q <= 1'b0;
			symbol_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			if (crc_ctrl.step) begin
				crc_idx_q <= crc_idx_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
					if (in_xfer) begin
						state_q   <= ST_RUN;
						nib_q     <= '0;
						crc_idx_q <= '0;
					end
				end
				ST_RUN: begin
					if (load) begin
						out_valid_q <= 1'b1;
						symbol_q    <= nibble_w;
						last_q      <= (nib_q == LAST_NIB_IDX);
						nib_q       <= nib_q + 1'b1;
						if (nib_q == LAST_NIB_IDX) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign symbol_nibble = symbol_q;
	assign last_nibble   = last_q;

endmodule

`default_nettype wire
